### design/mspbp_pkg.sv
// package for the max-score pair bin packer
`default_nettype none
package mspbp_pkg;
  localparam int MAX_ITEMS = 32;
  localparam int MAX_BINS = 16;
  localparam int SIZE_BITS = 16;
  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int BIN_W = $clog2(MAX_BINS);
  localparam int BCNT_W = $clog2(MAX_BINS + 1);

  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_BIN_COUNT = 2'd1;
  localparam logic [1:0] CFG_SCORE_MODE = 2'd2;

  localparam logic [1:0] MODE_PRODUCT = 2'd0;
  localparam logic [1:0] MODE_SLACK = 2'd1;
  localparam logic [1:0] MODE_RATIO = 2'd2;

  typedef enum logic [6:0] {
    ST_LOAD   = 7'b0000001,
    ST_INIT   = 7'b0000010,
    ST_RDI    = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_CMP    = 7'b0010000,
    ST_PLACE  = 7'b0100000,
    ST_SWAP   = 7'b1000000
  } state_t;
endpackage
`default_nettype wire

### design/max_score_pair_bin_packer.sv
// top level of the max-score pair bin packer
// load: one item beat per cycle while start is high and the packer is idle; the beat marked last_item starts the solve
// the solve first sets all bin residuals to the capacity; each placement scans every item left against every bin,
// then places the best fitting pair and swaps its item to the front; the next batch waits for the final beat
// item and residual state sit in synchronous memories; results are one-cycle strobes, no receiver stall
// synchronous active-low reset returns to the load state with default registers
`default_nettype none
module max_score_pair_bin_packer import mspbp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [15:0]          in_item_size,
  input  wire logic                 in_last_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data,
  output logic                      out_valid,
  output logic [4:0]                out_item_index,
  output logic [3:0]                out_bin_index,
  output logic                      out_infeasible,
  output logic [4:0]                out_bins_used,
  output logic                      out_overflow,
  output logic                      out_final_result
);
  logic [SIZE_BITS-1:0] size_mem [MAX_ITEMS];
  logic [IDX_W-1:0]     order_mem [MAX_ITEMS];
  logic [SIZE_BITS-1:0] res_mem [MAX_BINS];
  logic [MAX_BINS-1:0]  nonempty_r;

  logic [15:0] cap_r;
  logic [4:0] bcnt_r;
  logic [1:0] mode_r;

  state_t st_r;
  logic [CNT_W-1:0] loaded_r, first_r, i_r;
  logic [BIN_W:0] b_r;
  logic dropped_r;
  logic [BCNT_W-1:0] nb;

  logic [SIZE_BITS-1:0] s_rd, r_rd, o_s_rd;
  logic [IDX_W-1:0] o_rd, o_o_rd;
  logic have_r;
  logic [SIZE_BITS-1:0] best_s_r, best_r_r;
  logic [IDX_W-1:0] best_i_r;
  logic [BIN_W-1:0] best_b_r;
  logic [2*SIZE_BITS-1:0] pa_r, pb_r;
  logic fits_r;
  logic [SIZE_BITS-1:0] cand_s_r, cand_r_r;
  logic [IDX_W-1:0] cand_i_r;
  logic [BIN_W-1:0] cand_b_r;
  logic init_r;
  logic [BIN_W:0] ib_r;
  logic swap_ph_r;

  assign nb = (bcnt_r > 5'(MAX_BINS)) ? BCNT_W'(MAX_BINS) : BCNT_W'(bcnt_r);
  assign busy = (st_r != ST_LOAD);
  assign cfg_ready = (st_r == ST_LOAD);

  logic ld;
  assign ld = start && !busy;

  // pass-on counting of used bins
  logic [BCNT_W-1:0] used_cnt;
  always_comb begin
    used_cnt = '0;
    for (int k = 0; k < MAX_BINS; k++) begin
      if (nonempty_r[k] && BCNT_W'(k) < nb) used_cnt = used_cnt + 1'b1;
    end
  end

  // memory reads, addressed by state
  logic [IDX_W-1:0] i_addr;
  logic [BIN_W-1:0] b_addr;
  assign i_addr = i_r[IDX_W-1:0];
  assign b_addr = b_r[BIN_W-1:0];
  always_ff @(posedge clk) begin
    s_rd <= size_mem[i_addr];
    o_rd <= order_mem[i_addr];
    r_rd <= res_mem[b_addr];
    o_s_rd <= size_mem[first_r[IDX_W-1:0]];
    o_o_rd <= order_mem[first_r[IDX_W-1:0]];
  end

  // score compare of candidate against best
  logic beats;
  logic [SIZE_BITS-1:0] ra1, rb1;
  always_comb begin
    ra1 = (cand_r_r == '0) ? SIZE_BITS'(1) : cand_r_r;
    rb1 = (best_r_r == '0) ? SIZE_BITS'(1) : best_r_r;
    case (mode_r)
      MODE_SLACK: beats = (cand_r_r - cand_s_r) < (best_r_r - best_s_r);
      MODE_RATIO: beats = pa_r > pb_r;
      default:    beats = pa_r > pb_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mode_r == MODE_RATIO) begin
      pa_r <= cand_s_r * rb1;
      pb_r <= best_s_r * ra1;
    end else begin
      pa_r <= cand_s_r * cand_r_r;
      pb_r <= best_s_r * best_r_r;
    end
  end

  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (!rst_n) begin
      st_r <= ST_LOAD;
      cap_r <= 16'hFFFF;
      bcnt_r <= 5'd16;
      mode_r <= MODE_PRODUCT;
      loaded_r <= '0;
      first_r <= '0;
      dropped_r <= 1'b0;
      nonempty_r <= '0;
      have_r <= 1'b0;
      fits_r <= 1'b0;
      i_r <= '0;
      b_r <= '0;
      ib_r <= '0;
      init_r <= 1'b0;
      swap_ph_r <= 1'b0;
    end else begin
      case (st_r)
        ST_LOAD: begin
          if (cfg_valid) begin
            case (cfg_index)
              CFG_CAPACITY:   cap_r <= cfg_data;
              CFG_BIN_COUNT:  bcnt_r <= cfg_data[4:0];
              CFG_SCORE_MODE: mode_r <= cfg_data[1:0];
              default: ;
            endcase
          end
          if (ld) begin
            if (loaded_r < CNT_W'(MAX_ITEMS)) begin
              size_mem[loaded_r[IDX_W-1:0]] <= in_item_size[SIZE_BITS-1:0];
              order_mem[loaded_r[IDX_W-1:0]] <= loaded_r[IDX_W-1:0];
              loaded_r <= loaded_r + 1'b1;
            end else begin
              dropped_r <= 1'b1;
            end
            if (in_last_item) begin
              st_r <= ST_INIT;
              ib_r <= '0;
              nonempty_r <= '0;
            end
          end
        end
        ST_INIT: begin
          res_mem[ib_r[BIN_W-1:0]] <= cap_r[SIZE_BITS-1:0];
          ib_r <= ib_r + 1'b1;
          if (ib_r == (BIN_W+1)'(MAX_BINS - 1)) begin
            first_r <= '0;
            st_r <= ST_RDI;
          end
        end
        ST_RDI: begin
          // start a placement scan, or return to load once every item is placed
          have_r <= 1'b0;
          fits_r <= 1'b0;
          if (first_r == loaded_r) begin
            st_r <= ST_LOAD;
            loaded_r <= '0;
            first_r <= '0;
            dropped_r <= 1'b0;
          end else begin
            i_r <= first_r;
            b_r <= '0;
            st_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // the registered read is used once init_r is set, after i/b have stayed stable through the read
          if (init_r) begin
            init_r <= 1'b0;
            if (b_r < (BIN_W+1)'(nb) && s_rd <= r_rd) begin
              cand_s_r <= s_rd;
              cand_r_r <= r_rd;
              cand_i_r <= i_addr;
              cand_b_r <= b_addr;
              fits_r <= 1'b1;
            end else begin
              fits_r <= 1'b0;
            end
            st_r <= ST_CMP;
          end else begin
            init_r <= 1'b1;
          end
        end
        ST_CMP: begin
          if (!swap_ph_r) begin
            swap_ph_r <= 1'b1;
          end else begin
            swap_ph_r <= 1'b0;
            if (fits_r && (!have_r || beats)) begin
              have_r <= 1'b1;
              best_s_r <= cand_s_r;
              best_r_r <= cand_r_r;
              best_i_r <= cand_i_r;
              best_b_r <= cand_b_r;
            end
            fits_r <= 1'b0;
            if (b_r + 1'b1 < (BIN_W+1)'(nb)) begin
              b_r <= b_r + 1'b1;
              st_r <= ST_SCAN;
            end else if (i_r + 1'b1 < loaded_r) begin
              b_r <= '0;
              i_r <= i_r + 1'b1;
              st_r <= ST_SCAN;
            end else begin
              st_r <= ST_PLACE;
            end
            if (nb == '0) st_r <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          if (!have_r) begin
            out_valid <= 1'b1;
            out_item_index <= '0;
            out_bin_index <= '0;
            out_infeasible <= 1'b1;
            out_bins_used <= 5'(used_cnt);
            out_overflow <= dropped_r;
            out_final_result <= 1'b1;
            st_r <= ST_LOAD;
            loaded_r <= '0;
            first_r <= '0;
            dropped_r <= 1'b0;
          end else begin
            i_r <= CNT_W'(best_i_r);
            b_r <= (BIN_W+1)'(best_b_r);
            swap_ph_r <= 1'b0;
            st_r <= ST_SWAP;
          end
        end
        ST_SWAP: begin
          if (!swap_ph_r) begin
            swap_ph_r <= 1'b1;
          end else begin
            swap_ph_r <= 1'b0;
            res_mem[best_b_r] <= r_rd - s_rd;
            nonempty_r[best_b_r] <= 1'b1;
            size_mem[best_i_r] <= o_s_rd;
            order_mem[best_i_r] <= o_o_rd;
            size_mem[first_r[IDX_W-1:0]] <= s_rd;
            order_mem[first_r[IDX_W-1:0]] <= o_rd;
            first_r <= first_r + 1'b1;
            out_valid <= 1'b1;
            out_item_index <= 5'(o_rd);
            out_bin_index <= 4'(best_b_r);
            out_infeasible <= 1'b0;
            out_overflow <= dropped_r;
            if (first_r + 1'b1 == loaded_r) begin
              out_final_result <= 1'b1;
              // the bin chosen now counts even though its flag is set at this edge
              out_bins_used <= 5'(used_cnt) + (nonempty_r[best_b_r] ? 5'd0 : 5'd1);
            end else begin
              out_final_result <= 1'b0;
              out_bins_used <= '0;
            end
            st_r <= ST_RDI;
          end
        end
        default: st_r <= ST_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/mspbp_checker.sv
// port checker for the max-score pair bin packer, bound to the top level
`default_nettype none
module mspbp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_infeasible,
  input wire logic out_final_result,
  input wire logic [4:0] out_item_index,
  input wire logic [3:0] out_bin_index,
  input wire logic [4:0] out_bins_used
);
  a_inf_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_infeasible |-> out_final_result) else $error("infeasible not final");
  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_infeasible |-> out_item_index == 5'd0 && out_bin_index == 4'd0)
    else $error("infeasible pair not zero");
  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_result |-> out_bins_used == 5'd0) else $error("bins_used early");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_result |=> busy) else $error("idle mid solve");
endmodule

bind max_score_pair_bin_packer mspbp_checker u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_infeasible(out_infeasible), .out_final_result(out_final_result),
  .out_item_index(out_item_index), .out_bin_index(out_bin_index),
  .out_bins_used(out_bins_used)
);
`default_nettype wire
